FILE: rtl/assert_macros.svh
// Assertion macros used by the scheduler back end.
// The clock and reset names of the including module are used as they are.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define GDJS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GDJS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: rtl/gdjs_pkg.sv
// Types and constants for the greedy deadline job scheduler.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none

package gdjs_pkg;

   localparam int ID_W       = 8;
   localparam int DEADLINE_W = 8;
   localparam int PROFIT_W   = 16;
   localparam int SLOT_W     = 3;
   localparam int TOTAL_W    = 19;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [ID_W-1:0]       job_id;
      logic [DEADLINE_W-1:0] job_deadline;
      logic [PROFIT_W-1:0]   job_profit;
      logic                  last_job;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_index;
      logic [ID_W-1:0]     slot_job_id;
      logic [PROFIT_W-1:0] slot_profit;
      logic                slot_filled;
      logic [TOTAL_W-1:0]  total_profit;
      logic                overflow;
      logic                last_result;
   } rsp_type;

   // A classified job on its way from the front end to the back end.
   typedef struct packed {
      logic [ID_W-1:0]       job_id;
      logic [DEADLINE_W-1:0] deadline;
      logic [PROFIT_W-1:0]   profit;
      logic                  last;
      logic                  drop;
   } job_entry_type;

endpackage

`default_nettype wire

FILE: rtl/greedy_deadline_job_scheduler.sv
// Greedy deadline job scheduler. Jobs arrive one per transaction on req_ and are
// taken one per cycle, unless req_stall is high, into a two-entry queue; up to
// MAX_JOBS are stored, the rest are dropped and flagged. The job marked last
// starts scheduling: an exchange sort by profit (one store read per compare),
// then placement of each job in the latest free slot from its deadline down,
// then the results go out on rsp_, scanning slots up to the highest filled one.
// Results wait while rsp_stall holds the output register. While a set is
// scheduled the queue still takes up to two jobs of the next set, then req_stall
// stays high until the back end, back in its load state, takes a job from the
// queue.
`default_nettype none

module greedy_deadline_job_scheduler #(
   parameter int MAX_JOBS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  gdjs_pkg::req_type req_data,
   input  logic              req_valid,
   output logic              req_stall,
   output gdjs_pkg::rsp_type rsp_data,
   output logic              rsp_valid,
   input  logic              rsp_stall
);
   import gdjs_pkg::*;

   job_entry_type push_data;
   logic          push_valid;
   logic          push_full;
   job_entry_type pop_data;
   logic          pop_valid;
   logic          pop_ready;

   gdjs_front #(
      .MAX_JOBS(MAX_JOBS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_full  (push_full)
   );

   gdjs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_full  (push_full),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   gdjs_back #(
      .MAX_JOBS(MAX_JOBS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_data  (pop_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

FILE: rtl/gdjs_front.sv
// Front end of the scheduler: accepts job transactions, saturates deadlines
// and marks jobs beyond the store capacity. Depends on gdjs_pkg.
`default_nettype none

module gdjs_front #(
   parameter int MAX_JOBS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gdjs_pkg::req_type       req_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   output gdjs_pkg::job_entry_type push_data,
   output logic                    push_valid,
   input  logic                    push_full
);
   import gdjs_pkg::*;

   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             drop;

   assign req_stall = push_full;
   assign accept    = req_valid && !push_full;
   assign drop      = (cnt_ff == CNT_W'(MAX_JOBS));

   always_comb begin
      push_valid        = accept;
      push_data.job_id  = req_data.job_id;
      push_data.profit  = req_data.job_profit;
      push_data.last    = req_data.last_job;
      push_data.drop    = drop;
      if (req_data.job_deadline > DEADLINE_W'(MAX_JOBS)) begin
         push_data.deadline = DEADLINE_W'(MAX_JOBS);
      end else begin
         push_data.deadline = req_data.job_deadline;
      end
   end

   // The job count restarts with every set; a last job closes the set.
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_data.last_job) begin
            cnt_in = '0;
         end else if (!drop) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gdjs_queue.sv
// Short job queue between the scheduler front end and back end.
// Depends on gdjs_pkg for the entry type and depth.
`default_nettype none

module gdjs_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  gdjs_pkg::job_entry_type push_data,
   input  logic                    push_valid,
   output logic                    push_full,
   output gdjs_pkg::job_entry_type pop_data,
   output logic                    pop_valid,
   input  logic                    pop_ready
);
   import gdjs_pkg::*;

   job_entry_type     entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entries_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/gdjs_back.sv
// Back end of the scheduler: job store, exchange sort, slot placement and
// result sequencing with an output register. Depends on gdjs_pkg.
`default_nettype none

module gdjs_back #(
   parameter int MAX_JOBS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  gdjs_pkg::job_entry_type pop_data,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   output gdjs_pkg::rsp_type       rsp_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall
);
   import gdjs_pkg::*;

   `include "assert_macros.svh"

   localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W = $clog2(MAX_JOBS + 1);
   localparam int ST_W  = 4;

   localparam logic [ST_W-1:0] S_LOAD      = 4'd0;
   localparam logic [ST_W-1:0] S_SORT_ROW  = 4'd1;
   localparam logic [ST_W-1:0] S_SORT_CUR  = 4'd2;
   localparam logic [ST_W-1:0] S_SORT_CMP  = 4'd3;
   localparam logic [ST_W-1:0] S_SORT_WB   = 4'd4;
   localparam logic [ST_W-1:0] S_PLACE_RD  = 4'd5;
   localparam logic [ST_W-1:0] S_PLACE_GET = 4'd6;
   localparam logic [ST_W-1:0] S_PLACE_SRC = 4'd7;
   localparam logic [ST_W-1:0] S_EMIT_INIT = 4'd8;
   localparam logic [ST_W-1:0] S_EMIT_RD   = 4'd9;
   localparam logic [ST_W-1:0] S_EMIT_OUT  = 4'd10;
   localparam logic [ST_W-1:0] S_EMIT_NONE = 4'd11;

   // Job store: one write and one registered read per cycle.
   logic [ID_W-1:0]     jid_mem [MAX_JOBS];
   logic [CNT_W-1:0]    jdl_mem [MAX_JOBS];
   logic [PROFIT_W-1:0] jpf_mem [MAX_JOBS];
   logic                job_we;
   logic [IDX_W-1:0]    job_waddr;
   logic [IDX_W-1:0]    job_raddr;
   logic [ID_W-1:0]     job_wid;
   logic [CNT_W-1:0]    job_wdl;
   logic [PROFIT_W-1:0] job_wpf;
   logic [ID_W-1:0]     rd_id_ff;
   logic [CNT_W-1:0]    rd_dl_ff;
   logic [PROFIT_W-1:0] rd_pf_ff;

   // Slot store: holds the job placed in each slot.
   logic [ID_W-1:0]     sid_mem [MAX_JOBS];
   logic [PROFIT_W-1:0] spf_mem [MAX_JOBS];
   logic                slot_we;
   logic [IDX_W-1:0]    slot_waddr;
   logic [ID_W-1:0]     srd_id_ff;
   logic [PROFIT_W-1:0] srd_pf_ff;

   logic [ST_W-1:0]     state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                ovf_ff, ovf_in;
   logic [CNT_W-1:0]    i_ff, i_in;
   logic [CNT_W-1:0]    j_ff, j_in;
   logic [CNT_W-1:0]    s_ff, s_in;
   logic [MAX_JOBS-1:0] taken_ff, taken_in;
   logic                any_ff, any_in;
   logic [IDX_W-1:0]    max_ff, max_in;
   logic [IDX_W-1:0]    ej_ff, ej_in;
   logic [TOTAL_W-1:0]  run_ff, run_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [ID_W-1:0]     cur_id_ff, cur_id_in;
   logic [CNT_W-1:0]    cur_dl_ff, cur_dl_in;
   logic [PROFIT_W-1:0] cur_pf_ff, cur_pf_in;
   logic [ID_W-1:0]     pid_ff, pid_in;
   logic [PROFIT_W-1:0] ppf_ff, ppf_in;

   logic                out_free;
   logic                out_load;
   logic [IDX_W-1:0]    sidx;
   logic [CNT_W:0]      i_next;
   logic [CNT_W:0]      j_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop_ready = (state_ff == S_LOAD);
   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign sidx      = IDX_W'(s_ff - CNT_W'(1));
   assign i_next    = (CNT_W + 1)'(i_ff) + (CNT_W + 1)'(1);
   assign j_next    = (CNT_W + 1)'(j_ff) + (CNT_W + 1)'(1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      ovf_in    = ovf_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      s_in      = s_ff;
      taken_in  = taken_ff;
      any_in    = any_ff;
      max_in    = max_ff;
      ej_in     = ej_ff;
      run_in    = run_ff;
      cur_id_in = cur_id_ff;
      cur_dl_in = cur_dl_ff;
      cur_pf_in = cur_pf_ff;
      pid_in    = pid_ff;
      ppf_in    = ppf_ff;
      rsp_in    = rsp_ff;
      out_load  = 1'b0;

      job_we     = 1'b0;
      job_waddr  = i_ff[IDX_W-1:0];
      job_raddr  = i_ff[IDX_W-1:0];
      job_wid    = cur_id_ff;
      job_wdl    = cur_dl_ff;
      job_wpf    = cur_pf_ff;
      slot_we    = 1'b0;
      slot_waddr = sidx;

      unique case (state_ff)
         S_LOAD: begin
            job_waddr = cnt_ff[IDX_W-1:0];
            job_wid   = pop_data.job_id;
            job_wdl   = CNT_W'(pop_data.deadline);
            job_wpf   = pop_data.profit;
            if (pop_valid) begin
               if (pop_data.drop) begin
                  ovf_in = 1'b1;
               end else begin
                  job_we = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end
               if (pop_data.last) begin
                  n_in     = pop_data.drop ? cnt_ff : cnt_ff + CNT_W'(1);
                  i_in     = '0;
                  state_in = S_SORT_ROW;
               end
            end
         end
         S_SORT_ROW: begin
            if (i_next >= (CNT_W + 1)'(n_ff)) begin
               i_in     = '0;
               state_in = S_PLACE_RD;
            end else begin
               j_in     = CNT_W'(i_next);
               state_in = S_SORT_CUR;
            end
         end
         S_SORT_CUR: begin
            // Entry i is loaded into the current register, which then holds the highest profit seen in the row.
            cur_id_in = rd_id_ff;
            cur_dl_in = rd_dl_ff;
            cur_pf_in = rd_pf_ff;
            job_raddr = j_ff[IDX_W-1:0];
            state_in  = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            job_waddr = j_ff[IDX_W-1:0];
            if (cur_pf_ff < rd_pf_ff) begin
               job_we    = 1'b1;
               cur_id_in = rd_id_ff;
               cur_dl_in = rd_dl_ff;
               cur_pf_in = rd_pf_ff;
            end
            if (j_next < (CNT_W + 1)'(n_ff)) begin
               j_in      = CNT_W'(j_next);
               job_raddr = CNT_W'(j_next) < CNT_W'(MAX_JOBS) ? IDX_W'(j_next) : '0;
            end else begin
               state_in = S_SORT_WB;
            end
         end
         S_SORT_WB: begin
            job_we   = 1'b1;
            i_in     = CNT_W'(i_next);
            state_in = S_SORT_ROW;
         end
         S_PLACE_RD: begin
            if (i_ff >= n_ff) begin
               state_in = S_EMIT_INIT;
            end else begin
               state_in = S_PLACE_GET;
            end
         end
         S_PLACE_GET: begin
            pid_in = rd_id_ff;
            ppf_in = rd_pf_ff;
            if (rd_dl_ff == '0) begin
               i_in     = CNT_W'(i_next);
               state_in = S_PLACE_RD;
            end else begin
               s_in     = rd_dl_ff;
               state_in = S_PLACE_SRC;
            end
         end
         S_PLACE_SRC: begin
            // Walk down from the deadline to the latest free slot.
            if (!taken_ff[sidx]) begin
               taken_in[sidx] = 1'b1;
               slot_we        = 1'b1;
               any_in         = 1'b1;
               if (!any_ff || (sidx > max_ff)) begin
                  max_in = sidx;
               end
               i_in     = CNT_W'(i_next);
               state_in = S_PLACE_RD;
            end else if (s_ff == CNT_W'(1)) begin
               i_in     = CNT_W'(i_next);
               state_in = S_PLACE_RD;
            end else begin
               s_in = s_ff - CNT_W'(1);
            end
         end
         S_EMIT_INIT: begin
            ej_in  = '0;
            run_in = '0;
            if (any_ff) begin
               state_in = S_EMIT_RD;
            end else begin
               state_in = S_EMIT_NONE;
            end
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (taken_ff[ej_ff]) begin
               if (out_free) begin
                  out_load           = 1'b1;
                  run_in             = run_ff + TOTAL_W'(srd_pf_ff);
                  rsp_in.slot_index  = SLOT_W'(ej_ff);
                  rsp_in.slot_job_id = srd_id_ff;
                  rsp_in.slot_profit = srd_pf_ff;
                  rsp_in.slot_filled = 1'b1;
                  rsp_in.total_profit = run_ff + TOTAL_W'(srd_pf_ff);
                  rsp_in.overflow    = ovf_ff;
                  rsp_in.last_result = (ej_ff == max_ff);
                  if (ej_ff == max_ff) begin
                     cnt_in   = '0;
                     ovf_in   = 1'b0;
                     taken_in = '0;
                     any_in   = 1'b0;
                     state_in = S_LOAD;
                  end else begin
                     ej_in    = ej_ff + IDX_W'(1);
                     state_in = S_EMIT_RD;
                  end
               end
            end else begin
               ej_in    = ej_ff + IDX_W'(1);
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_NONE: begin
            if (out_free) begin
               out_load            = 1'b1;
               rsp_in.slot_index   = '0;
               rsp_in.slot_job_id  = '0;
               rsp_in.slot_profit  = '0;
               rsp_in.slot_filled  = 1'b0;
               rsp_in.total_profit = '0;
               rsp_in.overflow     = ovf_ff;
               rsp_in.last_result  = 1'b1;
               cnt_in   = '0;
               ovf_in   = 1'b0;
               taken_in = '0;
               any_in   = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         cnt_ff       <= '0;
         n_ff         <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         s_ff         <= '0;
         taken_ff     <= '0;
         any_ff       <= 1'b0;
         max_ff       <= '0;
         ej_ff        <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         s_ff         <= s_in;
         taken_ff     <= taken_in;
         any_ff       <= any_in;
         max_ff       <= max_in;
         ej_ff        <= ej_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      cur_id_ff <= cur_id_in;
      cur_dl_ff <= cur_dl_in;
      cur_pf_ff <= cur_pf_in;
      pid_ff    <= pid_in;
      ppf_ff    <= ppf_in;
   end

   always_ff @(posedge clock) begin
      if (job_we) begin
         jid_mem[job_waddr] <= job_wid;
         jdl_mem[job_waddr] <= job_wdl;
         jpf_mem[job_waddr] <= job_wpf;
      end
      rd_id_ff <= jid_mem[job_raddr];
      rd_dl_ff <= jdl_mem[job_raddr];
      rd_pf_ff <= jpf_mem[job_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         sid_mem[slot_waddr] <= pid_ff;
         spf_mem[slot_waddr] <= ppf_ff;
      end
      srd_id_ff <= sid_mem[ej_ff];
      srd_pf_ff <= spf_mem[ej_ff];
   end

   `GDJS_ASSERT(a_last_clears, out_load && rsp_in.last_result |=> state_ff == S_LOAD && taken_ff == '0, "set state not cleared after final result")
   `GDJS_ASSERT(a_search_nonzero, state_ff == S_PLACE_SRC |-> s_ff != '0, "slot search below slot zero")
   `GDJS_ASSERT(a_slots_bounded, $countones(taken_ff) <= n_ff, "more slots filled than jobs stored")

endmodule

`default_nettype wire
